FILE: rtl/core/x86d_pkg.sv
// x86d_pkg: shared types and constants of the 8086 instruction decoder
// no dependencies
`timescale 1ns / 1ps

package x86d_pkg;

	typedef enum logic [1:0] {
		PH_OPCODE = 2'd0,
		PH_MODRM  = 2'd1,
		PH_TAIL   = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		F_NONE  = 4'd0,
		F_MR    = 4'd1,
		F_RM    = 4'd2,
		F_ALU   = 4'd3,
		F_ALUSX = 4'd4,
		F_GRP3  = 4'd5,
		F_SEG   = 4'd6,
		F_POP   = 4'd7,
		F_SHIFT = 4'd8,
		F_GRP4  = 4'd9,
		F_GRP5  = 4'd10,
		F_MOVI  = 4'd11
	} fmt_t;

	// operand codes
	localparam logic [4:0] S_NONE = 5'd0;
	localparam logic [4:0] S_IMM  = 5'd1;
	localparam logic [4:0] S_DIR  = 5'd2;
	localparam logic [4:0] S_AL   = 5'd3;
	localparam logic [4:0] S_AX   = 5'd4;
	localparam logic [4:0] S_DX   = 5'd6;
	localparam logic [4:0] S_AH   = 5'd12;
	localparam logic [4:0] S_CL   = 5'd13;
	localparam logic [4:0] S_ES   = 5'd19;

	// operation codes
	localparam logic [6:0] O_NONE = 7'd0;
	localparam logic [6:0] O_ADD = 7'd1;
	localparam logic [6:0] O_PUSH = 7'd2;
	localparam logic [6:0] O_POP = 7'd3;
	localparam logic [6:0] O_OR = 7'd4;
	localparam logic [6:0] O_ADC = 7'd5;
	localparam logic [6:0] O_SBB = 7'd6;
	localparam logic [6:0] O_AND = 7'd7;
	localparam logic [6:0] O_DAA = 7'd8;
	localparam logic [6:0] O_SUB = 7'd9;
	localparam logic [6:0] O_DAS = 7'd10;
	localparam logic [6:0] O_XOR = 7'd11;
	localparam logic [6:0] O_AAA = 7'd12;
	localparam logic [6:0] O_CMP = 7'd13;
	localparam logic [6:0] O_AAS = 7'd14;
	localparam logic [6:0] O_INC = 7'd15;
	localparam logic [6:0] O_DEC = 7'd16;
	localparam logic [6:0] O_JO = 7'd17;
	localparam logic [6:0] O_TEST = 7'd33;
	localparam logic [6:0] O_XCHG = 7'd34;
	localparam logic [6:0] O_MOV = 7'd35;
	localparam logic [6:0] O_LEA = 7'd36;
	localparam logic [6:0] O_NOP = 7'd37;
	localparam logic [6:0] O_CBW = 7'd38;
	localparam logic [6:0] O_CWD = 7'd39;
	localparam logic [6:0] O_CALLF = 7'd40;
	localparam logic [6:0] O_WAIT = 7'd41;
	localparam logic [6:0] O_PUSHF = 7'd42;
	localparam logic [6:0] O_POPF = 7'd43;
	localparam logic [6:0] O_SAHF = 7'd44;
	localparam logic [6:0] O_LAHF = 7'd45;
	localparam logic [6:0] O_MOVS = 7'd46;
	localparam logic [6:0] O_CMPS = 7'd47;
	localparam logic [6:0] O_STOS = 7'd48;
	localparam logic [6:0] O_LODS = 7'd49;
	localparam logic [6:0] O_SCAS = 7'd50;
	localparam logic [6:0] O_RETN = 7'd51;
	localparam logic [6:0] O_LES = 7'd52;
	localparam logic [6:0] O_LDS = 7'd53;
	localparam logic [6:0] O_RETF = 7'd54;
	localparam logic [6:0] O_INT3 = 7'd55;
	localparam logic [6:0] O_INT = 7'd56;
	localparam logic [6:0] O_INTO = 7'd57;
	localparam logic [6:0] O_IRET = 7'd58;
	localparam logic [6:0] O_AAM = 7'd59;
	localparam logic [6:0] O_AAD = 7'd60;
	localparam logic [6:0] O_XLAT = 7'd61;
	localparam logic [6:0] O_ESC = 7'd62;
	localparam logic [6:0] O_LOOPNE = 7'd63;
	localparam logic [6:0] O_IN = 7'd67;
	localparam logic [6:0] O_OUT = 7'd68;
	localparam logic [6:0] O_CALLD = 7'd69;
	localparam logic [6:0] O_JMPN = 7'd70;
	localparam logic [6:0] O_JMPF = 7'd71;
	localparam logic [6:0] O_HLT = 7'd72;
	localparam logic [6:0] O_CMC = 7'd73;
	localparam logic [6:0] O_CLC = 7'd74;
	localparam logic [6:0] O_NOT = 7'd80;
	localparam logic [6:0] O_ROL = 7'd86;
	localparam logic [6:0] O_ROR = 7'd87;
	localparam logic [6:0] O_RCL = 7'd88;
	localparam logic [6:0] O_RCR = 7'd89;
	localparam logic [6:0] O_SAL = 7'd90;
	localparam logic [6:0] O_SHR = 7'd91;
	localparam logic [6:0] O_SAR = 7'd92;
	localparam logic [6:0] O_CALLN = 7'd93;

	localparam int unsigned TAIL_MAX = 6;

	function automatic logic [4:0] reg8(input logic [2:0] r);
		logic [4:0] t;
		unique case (r)
			3'd0: t = 5'd3;
			3'd1: t = 5'd13;
			3'd2: t = 5'd14;
			3'd3: t = 5'd15;
			3'd4: t = 5'd12;
			3'd5: t = 5'd16;
			3'd6: t = 5'd17;
			default: t = 5'd18;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] reg16(input logic [2:0] r);
		return 5'd4 + {2'd0, r};
	endfunction

	function automatic logic [4:0] reg_of(input logic [2:0] sz, input logic [2:0] r);
		logic [4:0] t;
		if (sz == 3'd1) t = reg8(r);
		else if (sz == 3'd2) t = reg16(r);
		else t = S_NONE;
		return t;
	endfunction

	function automatic logic [6:0] alu_op(input logic [2:0] r);
		logic [6:0] t;
		unique case (r)
			3'd0: t = O_ADD;
			3'd1: t = O_OR;
			3'd2: t = O_ADC;
			3'd3: t = O_SBB;
			3'd4: t = O_AND;
			3'd5: t = O_SUB;
			3'd6: t = O_XOR;
			default: t = O_CMP;
		endcase
		return t;
	endfunction

	function automatic logic [4:0] ind_mode(input logic [2:0] r);
		logic [4:0] t;
		unique case (r)
			3'd6: t = 5'd30;
			3'd7: t = 5'd29;
			default: t = 5'd23 + {2'd0, r};
		endcase
		return t;
	endfunction

	function automatic logic [6:0] shift_op(input logic [2:0] r);
		logic [6:0] t;
		unique case (r)
			3'd0: t = O_ROL;
			3'd1: t = O_ROR;
			3'd2: t = O_RCL;
			3'd3: t = O_RCR;
			3'd4: t = O_SAL;
			3'd5: t = O_SHR;
			3'd6: t = O_NONE;
			default: t = O_SAR;
		endcase
		return t;
	endfunction

	function automatic logic [6:0] grp5_op(input logic [2:0] r);
		logic [6:0] t;
		unique case (r)
			3'd0: t = O_INC;
			3'd1: t = O_DEC;
			3'd2: t = O_CALLN;
			3'd3: t = O_CALLF;
			3'd4: t = O_JMPN;
			3'd5: t = O_JMPF;
			3'd6: t = O_PUSH;
			default: t = O_NONE;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/core/x86_16bit_instruction_decoder.sv
// x86_16bit_instruction_decoder: 8086 byte-serial instruction decoder
// depends on x86d_pkg
//
//  channel | signals                               | beat
//  in      | in_valid, in_ready, code_byte         | one instruction byte
//  out     | out_valid, out_ready, status .. operand_value | one decoded record
//
// one byte per cycle: each beat is decoded by table logic into the parse state
// in the same cycle it is accepted; a record is written to the output register
// on the byte that ends an instruction (or shows it invalid)
// the output register holds a record until taken; a new byte is accepted while
// the register is empty or being emptied in that cycle
// arst_n clears parse state and the output valid flag
`timescale 1ns / 1ps

module x86_16bit_instruction_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  code_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [7:0]  length,
	output logic [6:0]  operation,
	output logic [4:0]  src_operand,
	output logic [4:0]  dst_operand,
	output logic        lock_flag,
	output logic [2:0]  segment_override,
	output logic [1:0]  repeat_mode,
	output logic [2:0]  op_size,
	output logic signed [15:0] displacement,
	output logic [31:0] operand_value
);

	// parse state
	x86d_pkg::phase_t phase_q;
	x86d_pkg::fmt_t   fmt_q;
	logic [7:0]  opc_q;
	logic [6:0]  op_q;
	logic [4:0]  src_q, dst_q;
	logic [2:0]  size_q;
	logic        lock_q;
	logic [2:0]  seg_q;
	logic [1:0]  rep_q;
	logic [1:0]  dbytes_q;
	logic [2:0]  ibytes_q;
	logic [2:0]  seen_q;
	logic [47:0] tail_q;
	logic [7:0]  count_q;

	// next-state values
	x86d_pkg::phase_t phase_d;
	x86d_pkg::fmt_t   fmt_d;
	logic [7:0]  opc_d;
	logic [6:0]  op_d;
	logic [4:0]  src_d, dst_d;
	logic [2:0]  size_d;
	logic        lock_d;
	logic [2:0]  seg_d;
	logic [1:0]  rep_d;
	logic [1:0]  dbytes_d;
	logic [2:0]  ibytes_d;
	logic [2:0]  seen_d;
	logic [47:0] tail_d;
	logic [7:0]  count_d;
	logic        done_c, bad_c;

	logic        accept;
	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	// opcode / modrm / tail decode
	always_comb begin
		logic [7:0] b;
		logic [2:0] lo, reg_f, rm;
		logic [1:0] md;
		logic [4:0] mem;
		logic [3:0] need;
		b = code_byte;
		lo = b[2:0];
		md = b[7:6];
		reg_f = b[5:3];
		rm = b[2:0];
		mem = x86d_pkg::S_NONE;
		need = 4'd0;
		phase_d = phase_q; fmt_d = fmt_q; opc_d = opc_q; op_d = op_q;
		src_d = src_q; dst_d = dst_q; size_d = size_q; lock_d = lock_q;
		seg_d = seg_q; rep_d = rep_q; dbytes_d = dbytes_q; ibytes_d = ibytes_q;
		seen_d = seen_q; tail_d = tail_q;
		count_d = (count_q == 8'hff) ? count_q : count_q + 8'd1;
		done_c = 1'b0; bad_c = 1'b0;
		unique case (phase_q)
			x86d_pkg::PH_OPCODE: begin
				opc_d = b;
				if (b < 8'h40 && lo < 3'd4) begin
					op_d = x86d_pkg::alu_op(b[5:3]);
					fmt_d = lo[1] ? x86d_pkg::F_RM : x86d_pkg::F_MR;
					size_d = lo[0] ? 3'd2 : 3'd1;
					phase_d = x86d_pkg::PH_MODRM;
				end else if (b < 8'h40 && lo < 3'd6) begin
					op_d = x86d_pkg::alu_op(b[5:3]);
					src_d = x86d_pkg::S_IMM;
					dst_d = lo[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
					size_d = lo[0] ? 3'd2 : 3'd1;
					ibytes_d = lo[0] ? 3'd2 : 3'd1;
					dbytes_d = 2'd0;
					phase_d = x86d_pkg::PH_TAIL;
				end else if (b < 8'h40) begin
					priority case (b)
						8'h06, 8'h0e, 8'h16, 8'h1e: begin
							op_d = x86d_pkg::O_PUSH; src_d = x86d_pkg::S_ES + {3'd0, b[4:3]};
							dst_d = x86d_pkg::S_NONE; size_d = 3'd2; done_c = 1'b1;
						end
						8'h07, 8'h17, 8'h1f: begin
							op_d = x86d_pkg::O_POP; src_d = x86d_pkg::S_ES + {3'd0, b[4:3]};
							dst_d = x86d_pkg::S_NONE; size_d = 3'd2; done_c = 1'b1;
						end
						8'h26, 8'h2e, 8'h36, 8'h3e: seg_d = 3'd1 + {1'b0, b[4:3]};
						8'h27: begin
							op_d = x86d_pkg::O_DAA; src_d = x86d_pkg::S_AL;
							dst_d = x86d_pkg::S_AL; size_d = 3'd1; done_c = 1'b1;
						end
						8'h2f: begin
							op_d = x86d_pkg::O_DAS; src_d = x86d_pkg::S_AL;
							dst_d = x86d_pkg::S_AL; size_d = 3'd1; done_c = 1'b1;
						end
						8'h37: begin
							op_d = x86d_pkg::O_AAA; src_d = x86d_pkg::S_AL;
							dst_d = x86d_pkg::S_AX; size_d = 3'd1; done_c = 1'b1;
						end
						8'h3f: begin
							op_d = x86d_pkg::O_AAS; src_d = x86d_pkg::S_AL;
							dst_d = x86d_pkg::S_AX; size_d = 3'd1; done_c = 1'b1;
						end
						default: bad_c = 1'b1;
					endcase
				end else if (b < 8'h60) begin
					unique case (b[4:3])
						2'd0: op_d = x86d_pkg::O_INC;
						2'd1: op_d = x86d_pkg::O_DEC;
						2'd2: op_d = x86d_pkg::O_PUSH;
						default: op_d = x86d_pkg::O_POP;
					endcase
					src_d = x86d_pkg::reg16(lo); dst_d = x86d_pkg::reg16(lo);
					size_d = 3'd2; done_c = 1'b1;
				end else if (b < 8'h70) begin
					bad_c = 1'b1;
				end else if (b < 8'h80) begin
					op_d = x86d_pkg::O_JO + {3'd0, b[3:0]};
					src_d = x86d_pkg::S_NONE; dst_d = x86d_pkg::S_NONE; size_d = 3'd0;
					ibytes_d = 3'd0; dbytes_d = 2'd1; phase_d = x86d_pkg::PH_TAIL;
				end else if (b >= 8'h91 && b <= 8'h97) begin
					op_d = x86d_pkg::O_XCHG; src_d = x86d_pkg::S_AX;
					dst_d = x86d_pkg::reg16(lo); size_d = 3'd2; done_c = 1'b1;
				end else if (b >= 8'hb0 && b <= 8'hbf) begin
					op_d = x86d_pkg::O_MOV; src_d = x86d_pkg::S_IMM;
					dst_d = b[3] ? x86d_pkg::reg16(lo) : x86d_pkg::reg8(lo);
					size_d = b[3] ? 3'd2 : 3'd1; ibytes_d = b[3] ? 3'd2 : 3'd1;
					dbytes_d = 2'd0; phase_d = x86d_pkg::PH_TAIL;
				end else if (b >= 8'hd8 && b <= 8'hdf) begin
					op_d = x86d_pkg::O_ESC; fmt_d = x86d_pkg::F_MR; size_d = 3'd0;
					phase_d = x86d_pkg::PH_MODRM;
				end else if (b >= 8'he0 && b <= 8'he3) begin
					op_d = x86d_pkg::O_LOOPNE + {5'd0, b[1:0]};
					src_d = x86d_pkg::S_NONE; dst_d = x86d_pkg::S_NONE; size_d = 3'd0;
					ibytes_d = 3'd0; dbytes_d = 2'd1; phase_d = x86d_pkg::PH_TAIL;
				end else begin
					// remaining single opcodes: defaults set up a one-byte record
					src_d = x86d_pkg::S_NONE; dst_d = x86d_pkg::S_NONE;
					dbytes_d = 2'd0; ibytes_d = 3'd0;
					priority case (b)
						8'h80, 8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
						8'h88, 8'h89, 8'h8a, 8'h8b, 8'h8d, 8'h8e, 8'h8f,
						8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hd0, 8'hd1, 8'hd2, 8'hd3,
						8'hf6, 8'hf7, 8'hfe, 8'hff: begin
							// modrm forms keep source/destination for later
							src_d = src_q; dst_d = dst_q;
							dbytes_d = dbytes_q; ibytes_d = ibytes_q;
							phase_d = x86d_pkg::PH_MODRM;
							size_d = b[0] ? 3'd2 : 3'd1;
							op_d = x86d_pkg::O_NONE;
							unique case (b)
								8'h80, 8'h81: fmt_d = x86d_pkg::F_ALU;
								8'h82, 8'h83: fmt_d = x86d_pkg::F_ALUSX;
								8'h84, 8'h85: begin
									op_d = x86d_pkg::O_TEST; fmt_d = x86d_pkg::F_MR;
								end
								8'h86, 8'h87: begin
									op_d = x86d_pkg::O_XCHG; fmt_d = x86d_pkg::F_RM;
								end
								8'h88, 8'h89: begin
									op_d = x86d_pkg::O_MOV; fmt_d = x86d_pkg::F_MR;
								end
								8'h8a, 8'h8b: begin
									op_d = x86d_pkg::O_MOV; fmt_d = x86d_pkg::F_RM;
								end
								8'h8d: begin
									op_d = x86d_pkg::O_LEA; fmt_d = x86d_pkg::F_RM;
									size_d = 3'd2;
								end
								8'h8e: begin
									op_d = x86d_pkg::O_MOV; fmt_d = x86d_pkg::F_SEG;
									size_d = 3'd2;
								end
								8'h8f: begin
									op_d = x86d_pkg::O_POP; fmt_d = x86d_pkg::F_POP;
									size_d = 3'd2;
								end
								8'hc4: begin
									op_d = x86d_pkg::O_LES; fmt_d = x86d_pkg::F_RM;
									size_d = 3'd2;
								end
								8'hc5: begin
									op_d = x86d_pkg::O_LDS; fmt_d = x86d_pkg::F_RM;
									size_d = 3'd2;
								end
								8'hc6, 8'hc7: begin
									op_d = x86d_pkg::O_MOV; fmt_d = x86d_pkg::F_MOVI;
								end
								8'hd0, 8'hd1: begin
									src_d = x86d_pkg::S_IMM; fmt_d = x86d_pkg::F_SHIFT;
								end
								8'hd2, 8'hd3: begin
									src_d = x86d_pkg::S_CL; fmt_d = x86d_pkg::F_SHIFT;
								end
								8'hf6, 8'hf7: fmt_d = x86d_pkg::F_GRP3;
								8'hfe: fmt_d = x86d_pkg::F_GRP4;
								default: begin
									fmt_d = x86d_pkg::F_GRP5; size_d = 3'd2;
								end
							endcase
						end
						8'h90: begin op_d = x86d_pkg::O_NOP; size_d = 3'd0; done_c = 1'b1; end
						8'h98: begin
							op_d = x86d_pkg::O_CBW; src_d = x86d_pkg::S_AL;
							dst_d = x86d_pkg::S_AH; size_d = 3'd1; done_c = 1'b1;
						end
						8'h99: begin
							op_d = x86d_pkg::O_CWD; src_d = x86d_pkg::S_AX;
							dst_d = x86d_pkg::S_DX; size_d = 3'd2; done_c = 1'b1;
						end
						8'h9a, 8'hea: begin
							op_d = b[7:4] == 4'h9 ? x86d_pkg::O_CALLF : x86d_pkg::O_JMPF;
							size_d = 3'd0; ibytes_d = 3'd4; phase_d = x86d_pkg::PH_TAIL;
						end
						8'h9b: begin op_d = x86d_pkg::O_WAIT; size_d = 3'd0; done_c = 1'b1; end
						8'h9c: begin op_d = x86d_pkg::O_PUSHF; size_d = 3'd2; done_c = 1'b1; end
						8'h9d: begin op_d = x86d_pkg::O_POPF; size_d = 3'd2; done_c = 1'b1; end
						8'h9e: begin op_d = x86d_pkg::O_SAHF; size_d = 3'd1; done_c = 1'b1; end
						8'h9f: begin op_d = x86d_pkg::O_LAHF; size_d = 3'd1; done_c = 1'b1; end
						8'ha0, 8'ha1, 8'ha2, 8'ha3: begin
							op_d = x86d_pkg::O_MOV;
							if (b[1]) begin
								src_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
								dst_d = x86d_pkg::S_DIR;
							end else begin
								src_d = x86d_pkg::S_DIR;
								dst_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
							end
							size_d = b[0] ? 3'd2 : 3'd1; ibytes_d = b[0] ? 3'd2 : 3'd1;
							phase_d = x86d_pkg::PH_TAIL;
						end
						8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'haa, 8'hab, 8'hac, 8'had,
						8'hae, 8'haf: begin
							unique case (b[3:1])
								3'b010: op_d = x86d_pkg::O_MOVS;
								3'b011: op_d = x86d_pkg::O_CMPS;
								3'b101: op_d = x86d_pkg::O_STOS;
								3'b110: op_d = x86d_pkg::O_LODS;
								default: op_d = x86d_pkg::O_SCAS;
							endcase
							size_d = b[0] ? 3'd2 : 3'd1; done_c = 1'b1;
						end
						8'ha8, 8'ha9: begin
							op_d = x86d_pkg::O_TEST; src_d = x86d_pkg::S_IMM;
							dst_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
							size_d = b[0] ? 3'd2 : 3'd1; ibytes_d = b[0] ? 3'd2 : 3'd1;
							phase_d = x86d_pkg::PH_TAIL;
						end
						8'hc2, 8'hca, 8'he8, 8'he9: begin
							unique case (b)
								8'hc2: op_d = x86d_pkg::O_RETN;
								8'hca: op_d = x86d_pkg::O_RETF;
								8'he8: op_d = x86d_pkg::O_CALLD;
								default: op_d = x86d_pkg::O_JMPN;
							endcase
							src_d = x86d_pkg::S_IMM; size_d = 3'd2; ibytes_d = 3'd2;
							phase_d = x86d_pkg::PH_TAIL;
						end
						8'hc3: begin op_d = x86d_pkg::O_RETN; size_d = 3'd2; done_c = 1'b1; end
						8'hcb: begin op_d = x86d_pkg::O_RETF; size_d = 3'd4; done_c = 1'b1; end
						8'hcc: begin op_d = x86d_pkg::O_INT3; size_d = 3'd0; done_c = 1'b1; end
						8'hcd: begin
							op_d = x86d_pkg::O_INT; src_d = x86d_pkg::S_IMM; size_d = 3'd1;
							ibytes_d = 3'd1; phase_d = x86d_pkg::PH_TAIL;
						end
						8'hce: begin op_d = x86d_pkg::O_INTO; size_d = 3'd0; done_c = 1'b1; end
						8'hcf: begin op_d = x86d_pkg::O_IRET; size_d = 3'd0; done_c = 1'b1; end
						8'hd4, 8'hd5: begin
							op_d = b[0] ? x86d_pkg::O_AAD : x86d_pkg::O_AAM;
							src_d = x86d_pkg::S_IMM; dst_d = x86d_pkg::S_AX; size_d = 3'd1;
							ibytes_d = 3'd1; phase_d = x86d_pkg::PH_TAIL;
						end
						8'hd7: begin op_d = x86d_pkg::O_XLAT; size_d = 3'd1; done_c = 1'b1; end
						8'he4, 8'he5, 8'he6, 8'he7: begin
							op_d = b[1] ? x86d_pkg::O_OUT : x86d_pkg::O_IN;
							if (b[1]) begin
								src_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
								dst_d = x86d_pkg::S_DIR;
							end else begin
								src_d = x86d_pkg::S_DIR;
								dst_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
							end
							size_d = b[0] ? 3'd2 : 3'd1; ibytes_d = 3'd1;
							phase_d = x86d_pkg::PH_TAIL;
						end
						8'heb: begin
							op_d = x86d_pkg::O_JMPN; size_d = 3'd0; dbytes_d = 2'd1;
							phase_d = x86d_pkg::PH_TAIL;
						end
						8'hec, 8'hed, 8'hee, 8'hef: begin
							op_d = b[1] ? x86d_pkg::O_OUT : x86d_pkg::O_IN;
							if (b[1]) begin
								src_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
								dst_d = x86d_pkg::S_DX;
							end else begin
								src_d = x86d_pkg::S_DX;
								dst_d = b[0] ? x86d_pkg::S_AX : x86d_pkg::S_AL;
							end
							size_d = b[0] ? 3'd2 : 3'd1; done_c = 1'b1;
						end
						// prefixes leave the pending record untouched
						8'hf0: begin
							lock_d = 1'b1; src_d = src_q; dst_d = dst_q;
							dbytes_d = dbytes_q; ibytes_d = ibytes_q;
						end
						8'hf2, 8'hf3: begin
							rep_d = b[0] ? 2'd2 : 2'd1; src_d = src_q; dst_d = dst_q;
							dbytes_d = dbytes_q; ibytes_d = ibytes_q;
						end
						8'hf4: begin op_d = x86d_pkg::O_HLT; size_d = 3'd1; done_c = 1'b1; end
						8'hf5: begin op_d = x86d_pkg::O_CMC; size_d = 3'd1; done_c = 1'b1; end
						8'hf8, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd: begin
							op_d = x86d_pkg::O_CLC + {4'd0, b[2:0]};
							size_d = 3'd1; done_c = 1'b1;
						end
						default: bad_c = 1'b1;
					endcase
				end
			end
			x86d_pkg::PH_MODRM: begin
				dbytes_d = 2'd0;
				ibytes_d = 3'd0;
				if (md == 2'd3) begin
					mem = x86d_pkg::reg_of(size_q, rm);
					if (op_q == x86d_pkg::O_LES || op_q == x86d_pkg::O_LDS) bad_c = 1'b1;
				end else if (md == 2'd0 && rm == 3'd6) begin
					mem = x86d_pkg::S_DIR; dbytes_d = 2'd2;
				end else begin
					mem = x86d_pkg::ind_mode(rm); dbytes_d = md;
				end
				unique case (fmt_q)
					x86d_pkg::F_MR: begin
						src_d = x86d_pkg::reg_of(size_q, reg_f); dst_d = mem;
					end
					x86d_pkg::F_RM: begin
						src_d = mem; dst_d = x86d_pkg::reg_of(size_q, reg_f);
					end
					x86d_pkg::F_ALU: begin
						op_d = x86d_pkg::alu_op(reg_f); src_d = x86d_pkg::S_IMM;
						dst_d = mem; ibytes_d = size_q;
					end
					x86d_pkg::F_ALUSX: begin
						if (reg_f == 3'd1 || reg_f == 3'd4 || reg_f == 3'd6) bad_c = 1'b1;
						op_d = x86d_pkg::alu_op(reg_f); src_d = x86d_pkg::S_IMM;
						dst_d = mem; ibytes_d = 3'd1;
					end
					x86d_pkg::F_GRP3: begin
						if (reg_f == 3'd1) bad_c = 1'b1;
						dst_d = mem;
						if (reg_f == 3'd0) begin
							op_d = x86d_pkg::O_TEST; src_d = x86d_pkg::S_IMM; ibytes_d = size_q;
						end else begin
							op_d = x86d_pkg::O_NOT + {4'd0, reg_f} - 7'd2; src_d = mem;
						end
					end
					x86d_pkg::F_SEG: begin
						if (reg_f[2]) bad_c = 1'b1;
						src_d = mem; dst_d = x86d_pkg::S_ES + {2'd0, reg_f};
					end
					x86d_pkg::F_POP: begin
						if (reg_f != 3'd0) bad_c = 1'b1;
						src_d = mem; dst_d = mem;
					end
					x86d_pkg::F_SHIFT: begin
						if (x86d_pkg::shift_op(reg_f) == x86d_pkg::O_NONE) bad_c = 1'b1;
						op_d = x86d_pkg::shift_op(reg_f); dst_d = mem;
					end
					x86d_pkg::F_GRP4: begin
						if (reg_f > 3'd1) bad_c = 1'b1;
						op_d = x86d_pkg::O_INC + {4'd0, reg_f}; src_d = mem; dst_d = mem;
					end
					x86d_pkg::F_GRP5: begin
						if (x86d_pkg::grp5_op(reg_f) == x86d_pkg::O_NONE) bad_c = 1'b1;
						op_d = x86d_pkg::grp5_op(reg_f); src_d = mem; dst_d = mem;
					end
					x86d_pkg::F_MOVI: begin
						src_d = x86d_pkg::S_IMM; dst_d = mem; ibytes_d = size_q;
					end
					default: bad_c = 1'b1;
				endcase
				if (!bad_c) begin
					if (dbytes_d == 2'd0 && ibytes_d == 3'd0) done_c = 1'b1;
					else phase_d = x86d_pkg::PH_TAIL;
				end
			end
			default: begin
				// tail bytes: displacement then immediate, little-endian
				need = {2'd0, dbytes_q} + {1'b0, ibytes_q};
				if (seen_q < 3'(x86d_pkg::TAIL_MAX)) begin
					tail_d = tail_q | (48'(b) << {seen_q, 3'd0});
					seen_d = seen_q + 3'd1;
				end
				if ({1'b0, seen_d} >= need || seen_d >= 3'(x86d_pkg::TAIL_MAX)) done_c = 1'b1;
			end
		endcase
	end

	// record assembly from next-state values
	logic [15:0] disp_c;
	logic [31:0] opnd_c;
	logic [47:0] rest_c;
	always_comb begin
		disp_c = 16'd0;
		opnd_c = 32'd0;
		rest_c = tail_d;
		if (dbytes_d == 2'd1) begin
			disp_c = {{8{tail_d[7]}}, tail_d[7:0]};
			rest_c = tail_d >> 8;
		end else if (dbytes_d >= 2'd2) begin
			disp_c = tail_d[15:0];
			rest_c = tail_d >> 16;
		end
		if (ibytes_d == 3'd1) begin
			opnd_c = {24'd0, rest_c[7:0]};
			if (size_d == 3'd2 && op_d != x86d_pkg::O_IN && op_d != x86d_pkg::O_OUT
				&& rest_c[7])
				opnd_c[15:8] = 8'hff;
		end else if (ibytes_d == 3'd2) begin
			opnd_c = {16'd0, rest_c[15:0]};
		end else if (ibytes_d >= 3'd4) begin
			opnd_c = rest_c[31:0];
		end else if (opc_d == 8'hd0 || opc_d == 8'hd1) begin
			opnd_c = 32'd1;
		end
	end

	logic emit;
	assign emit = accept && (done_c || bad_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= x86d_pkg::PH_OPCODE;
			fmt_q <= x86d_pkg::F_NONE;
			opc_q <= 8'd0; op_q <= 7'd0; src_q <= 5'd0; dst_q <= 5'd0; size_q <= 3'd0;
			lock_q <= 1'b0; seg_q <= 3'd0; rep_q <= 2'd0; dbytes_q <= 2'd0;
			ibytes_q <= 3'd0; seen_q <= 3'd0; tail_q <= 48'd0; count_q <= 8'd0;
		end else if (accept) begin
			if (emit) begin
				// back to a clean parse after every record
				phase_q <= x86d_pkg::PH_OPCODE;
				fmt_q <= x86d_pkg::F_NONE;
				opc_q <= 8'd0; op_q <= 7'd0; src_q <= 5'd0; dst_q <= 5'd0;
				size_q <= 3'd0; lock_q <= 1'b0; seg_q <= 3'd0; rep_q <= 2'd0;
				dbytes_q <= 2'd0; ibytes_q <= 3'd0; seen_q <= 3'd0;
				tail_q <= 48'd0; count_q <= 8'd0;
			end else begin
				phase_q <= phase_d; fmt_q <= fmt_d; opc_q <= opc_d; op_q <= op_d;
				src_q <= src_d; dst_q <= dst_d; size_q <= size_d; lock_q <= lock_d;
				seg_q <= seg_d; rep_q <= rep_d; dbytes_q <= dbytes_d;
				ibytes_q <= ibytes_d; seen_q <= seen_d; tail_q <= tail_d;
				count_q <= count_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status <= bad_c;
			length <= count_d;
			if (bad_c) begin
				// invalid record carries only status and length
				operation <= 7'd0; src_operand <= 5'd0; dst_operand <= 5'd0;
				lock_flag <= 1'b0; segment_override <= 3'd0; repeat_mode <= 2'd0;
				op_size <= 3'd0; displacement <= 16'sd0; operand_value <= 32'd0;
			end else begin
				operation <= op_d; src_operand <= src_d; dst_operand <= dst_d;
				lock_flag <= lock_d; segment_override <= seg_d; repeat_mode <= rep_d;
				op_size <= size_d; displacement <= disp_c; operand_value <= opnd_c;
			end
		end
	end

endmodule

FILE: tb/sv/x86d_checker.sv
// x86d_checker: watches both channels of the 8086 decoder, predicts each record
// from the accepted bytes and compares it field by field; depends on x86d_pkg
`timescale 1ns / 1ps

module x86d_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  code_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        status,
	input  logic [7:0]  length,
	input  logic [6:0]  operation,
	input  logic [4:0]  src_operand,
	input  logic [4:0]  dst_operand,
	input  logic        lock_flag,
	input  logic [2:0]  segment_override,
	input  logic [1:0]  repeat_mode,
	input  logic [2:0]  op_size,
	input  logic signed [15:0] displacement,
	input  logic [31:0] operand_value,
	output int          fail_count,
	output int          pending_records,
	output int          records_seen,
	output int          rejects_seen
);

	typedef struct packed {
		logic        bad;
		logic [7:0]  len;
		logic [6:0]  op;
		logic [4:0]  src;
		logic [4:0]  dst;
		logic        lock;
		logic [2:0]  seg;
		logic [1:0]  rep;
		logic [2:0]  size;
		logic [15:0] disp;
		logic [31:0] opnd;
	} decoded_t;

	decoded_t expected_records[$];

	// decoder state, mirrors the parse registers
	x86d_pkg::phase_t ph;
	x86d_pkg::fmt_t   fmt;
	logic [7:0]  opc;
	logic [6:0]  p_op;
	logic [4:0]  p_src, p_dst;
	logic [2:0]  p_size;
	logic        p_lock;
	logic [2:0]  p_seg;
	logic [1:0]  p_rep;
	logic [1:0]  n_disp;
	logic [2:0]  n_imm;
	logic [2:0]  n_tail;
	logic [47:0] tail;
	logic [7:0]  count;

	localparam int ST_WAIT = 0, ST_DONE = 1, ST_BAD = 2;

	function automatic logic [4:0] r8(input logic [2:0] r);
		logic [4:0] t [8] = '{5'd3, 5'd13, 5'd14, 5'd15, 5'd12, 5'd16, 5'd17, 5'd18};
		return t[r];
	endfunction

	function automatic logic [4:0] reg_sel(input logic [2:0] sz, input logic [2:0] r);
		if (sz == 3'd1) return r8(r);
		if (sz == 3'd2) return 5'd4 + {2'd0, r};
		return x86d_pkg::S_NONE;
	endfunction

	function automatic logic [6:0] alu_sel(input logic [2:0] r);
		logic [6:0] t [8] = '{x86d_pkg::O_ADD, x86d_pkg::O_OR, x86d_pkg::O_ADC,
			x86d_pkg::O_SBB, x86d_pkg::O_AND, x86d_pkg::O_SUB, x86d_pkg::O_XOR,
			x86d_pkg::O_CMP};
		return t[r];
	endfunction

	task automatic clear_decode();
		ph = x86d_pkg::PH_OPCODE; fmt = x86d_pkg::F_NONE; opc = '0; p_op = x86d_pkg::O_NONE;
		p_src = x86d_pkg::S_NONE; p_dst = x86d_pkg::S_NONE; p_size = '0; p_lock = 0;
		p_seg = '0; p_rep = '0; n_disp = '0; n_imm = '0; n_tail = '0; tail = '0; count = '0;
	endtask

	task automatic set_rec(input logic [6:0] op, input logic [4:0] s, input logic [4:0] d,
			input logic [2:0] sz);
		p_op = op; p_src = s; p_dst = d; p_size = sz;
	endtask

	task automatic go_tail(input logic [6:0] op, input logic [4:0] s, input logic [4:0] d,
			input logic [2:0] sz, input logic [2:0] imm, input logic [1:0] dsp, output int r);
		set_rec(op, s, d, sz); n_imm = imm; n_disp = dsp; ph = x86d_pkg::PH_TAIL;
		r = ST_WAIT;
	endtask

	task automatic go_modrm(input logic [6:0] op, input x86d_pkg::fmt_t f,
			input logic [2:0] sz, output int r);
		p_op = op; fmt = f; p_size = sz; ph = x86d_pkg::PH_MODRM; r = ST_WAIT;
	endtask

	task automatic decode_opcode(input logic [7:0] b, output int r);
		logic [2:0] lo;
		logic [6:0] aop;
		lo = b[2:0];
		opc = b;
		r = ST_DONE;
		if (b < 8'h40) begin
			aop = alu_sel(b[5:3]);
			case (lo)
				3'd0: go_modrm(aop, x86d_pkg::F_MR, 3'd1, r);
				3'd1: go_modrm(aop, x86d_pkg::F_MR, 3'd2, r);
				3'd2: go_modrm(aop, x86d_pkg::F_RM, 3'd1, r);
				3'd3: go_modrm(aop, x86d_pkg::F_RM, 3'd2, r);
				3'd4: go_tail(aop, x86d_pkg::S_IMM, x86d_pkg::S_AL, 3'd1, 3'd1, 2'd0, r);
				3'd5: go_tail(aop, x86d_pkg::S_IMM, x86d_pkg::S_AX, 3'd2, 3'd2, 2'd0, r);
				3'd6: begin
					if (b[5]) begin
						// segment override prefix
						p_seg = 3'd1 + {1'b0, b[4:3]};
						r = ST_WAIT;
					end else set_rec(x86d_pkg::O_PUSH, x86d_pkg::S_ES + {3'd0, b[4:3]},
						x86d_pkg::S_NONE, 3'd2);
				end
				default: begin
					if (b == 8'h0f) r = ST_BAD;
					else if (!b[5]) set_rec(x86d_pkg::O_POP,
						x86d_pkg::S_ES + {3'd0, b[4:3]}, x86d_pkg::S_NONE, 3'd2);
					else if (b == 8'h27)
						set_rec(x86d_pkg::O_DAA, x86d_pkg::S_AL, x86d_pkg::S_AL, 3'd1);
					else if (b == 8'h2f)
						set_rec(x86d_pkg::O_DAS, x86d_pkg::S_AL, x86d_pkg::S_AL, 3'd1);
					else if (b == 8'h37)
						set_rec(x86d_pkg::O_AAA, x86d_pkg::S_AL, x86d_pkg::S_AX, 3'd1);
					else set_rec(x86d_pkg::O_AAS, x86d_pkg::S_AL, x86d_pkg::S_AX, 3'd1);
				end
			endcase
		end else if (b < 8'h60) begin
			case (b[4:3])
				2'd0: aop = x86d_pkg::O_INC;
				2'd1: aop = x86d_pkg::O_DEC;
				2'd2: aop = x86d_pkg::O_PUSH;
				default: aop = x86d_pkg::O_POP;
			endcase
			set_rec(aop, 5'd4 + {2'd0, lo}, 5'd4 + {2'd0, lo}, 3'd2);
		end else if (b < 8'h70) r = ST_BAD;
		else if (b < 8'h80) go_tail(x86d_pkg::O_JO + {3'd0, b[3:0]}, x86d_pkg::S_NONE,
			x86d_pkg::S_NONE, 3'd0, 3'd0, 2'd1, r);
		else if (b >= 8'h91 && b <= 8'h97)
			set_rec(x86d_pkg::O_XCHG, x86d_pkg::S_AX, 5'd4 + {2'd0, lo}, 3'd2);
		else if (b >= 8'hb0 && b <= 8'hb7)
			go_tail(x86d_pkg::O_MOV, x86d_pkg::S_IMM, r8(lo), 3'd1, 3'd1, 2'd0, r);
		else if (b >= 8'hb8 && b <= 8'hbf)
			go_tail(x86d_pkg::O_MOV, x86d_pkg::S_IMM, 5'd4 + {2'd0, lo}, 3'd2, 3'd2, 2'd0, r);
		else if (b >= 8'hd8 && b <= 8'hdf) go_modrm(x86d_pkg::O_ESC, x86d_pkg::F_MR, 3'd0, r);
		else if (b >= 8'he0 && b <= 8'he3)
			go_tail(x86d_pkg::O_LOOPNE + {5'd0, b[1:0]}, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
				3'd0, 3'd0, 2'd1, r);
		else if (b >= 8'hf8 && b <= 8'hfd)
			set_rec(x86d_pkg::O_CLC + {4'd0, b[2:0]}, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
		else begin
			case (b)
				8'h80: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_ALU, 3'd1, r);
				8'h81: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_ALU, 3'd2, r);
				8'h82: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_ALUSX, 3'd1, r);
				8'h83: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_ALUSX, 3'd2, r);
				8'h84: go_modrm(x86d_pkg::O_TEST, x86d_pkg::F_MR, 3'd1, r);
				8'h85: go_modrm(x86d_pkg::O_TEST, x86d_pkg::F_MR, 3'd2, r);
				8'h86: go_modrm(x86d_pkg::O_XCHG, x86d_pkg::F_RM, 3'd1, r);
				8'h87: go_modrm(x86d_pkg::O_XCHG, x86d_pkg::F_RM, 3'd2, r);
				8'h88: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_MR, 3'd1, r);
				8'h89: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_MR, 3'd2, r);
				8'h8a: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_RM, 3'd1, r);
				8'h8b: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_RM, 3'd2, r);
				8'h8d: go_modrm(x86d_pkg::O_LEA, x86d_pkg::F_RM, 3'd2, r);
				8'h8e: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_SEG, 3'd2, r);
				8'h8f: go_modrm(x86d_pkg::O_POP, x86d_pkg::F_POP, 3'd2, r);
				8'h90: set_rec(x86d_pkg::O_NOP, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0);
				8'h98: set_rec(x86d_pkg::O_CBW, x86d_pkg::S_AL, x86d_pkg::S_AH, 3'd1);
				8'h99: set_rec(x86d_pkg::O_CWD, x86d_pkg::S_AX, x86d_pkg::S_DX, 3'd2);
				8'h9a: go_tail(x86d_pkg::O_CALLF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0, 3'd4,
					2'd0, r);
				8'h9b: set_rec(x86d_pkg::O_WAIT, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0);
				8'h9c: set_rec(x86d_pkg::O_PUSHF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd2);
				8'h9d: set_rec(x86d_pkg::O_POPF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd2);
				8'h9e: set_rec(x86d_pkg::O_SAHF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
				8'h9f: set_rec(x86d_pkg::O_LAHF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
				8'ha0: go_tail(x86d_pkg::O_MOV, x86d_pkg::S_DIR, x86d_pkg::S_AL, 3'd1, 3'd1,
					2'd0, r);
				8'ha1: go_tail(x86d_pkg::O_MOV, x86d_pkg::S_DIR, x86d_pkg::S_AX, 3'd2, 3'd2,
					2'd0, r);
				8'ha2: go_tail(x86d_pkg::O_MOV, x86d_pkg::S_AL, x86d_pkg::S_DIR, 3'd1, 3'd1,
					2'd0, r);
				8'ha3: go_tail(x86d_pkg::O_MOV, x86d_pkg::S_AX, x86d_pkg::S_DIR, 3'd2, 3'd2,
					2'd0, r);
				8'ha4, 8'ha5: set_rec(x86d_pkg::O_MOVS, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
					3'd1 + {2'd0, b[0]});
				8'ha6, 8'ha7: set_rec(x86d_pkg::O_CMPS, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
					3'd1 + {2'd0, b[0]});
				8'ha8: go_tail(x86d_pkg::O_TEST, x86d_pkg::S_IMM, x86d_pkg::S_AL, 3'd1, 3'd1,
					2'd0, r);
				8'ha9: go_tail(x86d_pkg::O_TEST, x86d_pkg::S_IMM, x86d_pkg::S_AX, 3'd2, 3'd2,
					2'd0, r);
				8'haa, 8'hab: set_rec(x86d_pkg::O_STOS, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
					3'd1 + {2'd0, b[0]});
				8'hac, 8'had: set_rec(x86d_pkg::O_LODS, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
					3'd1 + {2'd0, b[0]});
				8'hae, 8'haf: set_rec(x86d_pkg::O_SCAS, x86d_pkg::S_NONE, x86d_pkg::S_NONE,
					3'd1 + {2'd0, b[0]});
				8'hc2: go_tail(x86d_pkg::O_RETN, x86d_pkg::S_IMM, x86d_pkg::S_NONE, 3'd2, 3'd2,
					2'd0, r);
				8'hc3: set_rec(x86d_pkg::O_RETN, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd2);
				8'hc4: go_modrm(x86d_pkg::O_LES, x86d_pkg::F_RM, 3'd2, r);
				8'hc5: go_modrm(x86d_pkg::O_LDS, x86d_pkg::F_RM, 3'd2, r);
				8'hc6: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_MOVI, 3'd1, r);
				8'hc7: go_modrm(x86d_pkg::O_MOV, x86d_pkg::F_MOVI, 3'd2, r);
				8'hca: go_tail(x86d_pkg::O_RETF, x86d_pkg::S_IMM, x86d_pkg::S_NONE, 3'd2, 3'd2,
					2'd0, r);
				8'hcb: set_rec(x86d_pkg::O_RETF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd4);
				8'hcc: set_rec(x86d_pkg::O_INT3, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0);
				8'hcd: go_tail(x86d_pkg::O_INT, x86d_pkg::S_IMM, x86d_pkg::S_NONE, 3'd1, 3'd1,
					2'd0, r);
				8'hce: set_rec(x86d_pkg::O_INTO, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0);
				8'hcf: set_rec(x86d_pkg::O_IRET, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0);
				8'hd0, 8'hd1: begin
					p_src = x86d_pkg::S_IMM;
					go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_SHIFT, 3'd1 + {2'd0, b[0]}, r);
				end
				8'hd2, 8'hd3: begin
					p_src = x86d_pkg::S_CL;
					go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_SHIFT, 3'd1 + {2'd0, b[0]}, r);
				end
				8'hd4: go_tail(x86d_pkg::O_AAM, x86d_pkg::S_IMM, x86d_pkg::S_AX, 3'd1, 3'd1,
					2'd0, r);
				8'hd5: go_tail(x86d_pkg::O_AAD, x86d_pkg::S_IMM, x86d_pkg::S_AX, 3'd1, 3'd1,
					2'd0, r);
				8'hd7: set_rec(x86d_pkg::O_XLAT, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
				8'he4: go_tail(x86d_pkg::O_IN, x86d_pkg::S_DIR, x86d_pkg::S_AL, 3'd1, 3'd1,
					2'd0, r);
				8'he5: go_tail(x86d_pkg::O_IN, x86d_pkg::S_DIR, x86d_pkg::S_AX, 3'd2, 3'd1,
					2'd0, r);
				8'he6: go_tail(x86d_pkg::O_OUT, x86d_pkg::S_AL, x86d_pkg::S_DIR, 3'd1, 3'd1,
					2'd0, r);
				8'he7: go_tail(x86d_pkg::O_OUT, x86d_pkg::S_AX, x86d_pkg::S_DIR, 3'd2, 3'd1,
					2'd0, r);
				8'he8: go_tail(x86d_pkg::O_CALLD, x86d_pkg::S_IMM, x86d_pkg::S_NONE, 3'd2, 3'd2,
					2'd0, r);
				8'he9: go_tail(x86d_pkg::O_JMPN, x86d_pkg::S_IMM, x86d_pkg::S_NONE, 3'd2, 3'd2,
					2'd0, r);
				8'hea: go_tail(x86d_pkg::O_JMPF, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0, 3'd4,
					2'd0, r);
				8'heb: go_tail(x86d_pkg::O_JMPN, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd0, 3'd0,
					2'd1, r);
				8'hec: set_rec(x86d_pkg::O_IN, x86d_pkg::S_DX, x86d_pkg::S_AL, 3'd1);
				8'hed: set_rec(x86d_pkg::O_IN, x86d_pkg::S_DX, x86d_pkg::S_AX, 3'd2);
				8'hee: set_rec(x86d_pkg::O_OUT, x86d_pkg::S_AL, x86d_pkg::S_DX, 3'd1);
				8'hef: set_rec(x86d_pkg::O_OUT, x86d_pkg::S_AX, x86d_pkg::S_DX, 3'd2);
				8'hf0: begin p_lock = 1'b1; r = ST_WAIT; end
				8'hf2: begin p_rep = 2'd1; r = ST_WAIT; end
				8'hf3: begin p_rep = 2'd2; r = ST_WAIT; end
				8'hf4: set_rec(x86d_pkg::O_HLT, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
				8'hf5: set_rec(x86d_pkg::O_CMC, x86d_pkg::S_NONE, x86d_pkg::S_NONE, 3'd1);
				8'hf6: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_GRP3, 3'd1, r);
				8'hf7: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_GRP3, 3'd2, r);
				8'hfe: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_GRP4, 3'd1, r);
				8'hff: go_modrm(x86d_pkg::O_NONE, x86d_pkg::F_GRP5, 3'd2, r);
				default: r = ST_BAD;
			endcase
		end
	endtask

	task automatic decode_modrm(input logic [7:0] m, output int r);
		logic [1:0] md;
		logic [2:0] rg, rm;
		logic [4:0] mem;
		logic [6:0] t5 [8];
		md = m[7:6]; rg = m[5:3]; rm = m[2:0];
		t5 = '{x86d_pkg::O_INC, x86d_pkg::O_DEC, x86d_pkg::O_CALLN, x86d_pkg::O_CALLF,
			x86d_pkg::O_JMPN, x86d_pkg::O_JMPF, x86d_pkg::O_PUSH, x86d_pkg::O_NONE};
		n_disp = '0; n_imm = '0; r = ST_WAIT;
		if (md == 2'd3) begin
			mem = reg_sel(p_size, rm);
			if (p_op == x86d_pkg::O_LES || p_op == x86d_pkg::O_LDS) r = ST_BAD;
		end else if (md == 2'd0 && rm == 3'd6) begin
			mem = x86d_pkg::S_DIR; n_disp = 2'd2;
		end else begin
			mem = (rm == 3'd6) ? 5'd30 : (rm == 3'd7) ? 5'd29 : 5'd23 + {2'd0, rm};
			n_disp = md;
		end
		if (r == ST_BAD) return;
		case (fmt)
			x86d_pkg::F_MR: begin p_src = reg_sel(p_size, rg); p_dst = mem; end
			x86d_pkg::F_RM: begin p_src = mem; p_dst = reg_sel(p_size, rg); end
			x86d_pkg::F_ALU: begin
				p_op = alu_sel(rg); p_src = x86d_pkg::S_IMM; p_dst = mem; n_imm = p_size;
			end
			x86d_pkg::F_ALUSX: begin
				if (rg == 3'd1 || rg == 3'd4 || rg == 3'd6) r = ST_BAD;
				p_op = alu_sel(rg); p_src = x86d_pkg::S_IMM; p_dst = mem; n_imm = 3'd1;
			end
			x86d_pkg::F_GRP3: begin
				if (rg == 3'd1) r = ST_BAD;
				p_src = mem; p_dst = mem;
				if (rg == 3'd0) begin
					p_op = x86d_pkg::O_TEST; p_src = x86d_pkg::S_IMM; n_imm = p_size;
				end else p_op = x86d_pkg::O_NOT + {4'd0, rg} - 7'd2;
			end
			x86d_pkg::F_SEG: begin
				if (rg[2]) r = ST_BAD;
				p_src = mem; p_dst = x86d_pkg::S_ES + {2'd0, rg};
			end
			x86d_pkg::F_POP: begin
				if (rg != 3'd0) r = ST_BAD;
				p_src = mem; p_dst = mem;
			end
			x86d_pkg::F_SHIFT: begin
				if (rg == 3'd6) r = ST_BAD;
				p_op = (rg == 3'd7) ? x86d_pkg::O_SAR : x86d_pkg::O_ROL + {4'd0, rg};
				p_dst = mem;
			end
			x86d_pkg::F_GRP4: begin
				if (rg > 3'd1) r = ST_BAD;
				p_op = x86d_pkg::O_INC + {4'd0, rg}; p_src = mem; p_dst = mem;
			end
			x86d_pkg::F_GRP5: begin
				if (rg == 3'd7) r = ST_BAD;
				p_op = t5[rg]; p_src = mem; p_dst = mem;
			end
			x86d_pkg::F_MOVI: begin p_src = x86d_pkg::S_IMM; p_dst = mem; n_imm = p_size; end
			default: r = ST_BAD;
		endcase
		if (r == ST_BAD) return;
		if ({1'b0, n_disp} + n_imm == 3'd0) r = ST_DONE;
		else ph = x86d_pkg::PH_TAIL;
	endtask

	function automatic decoded_t build_record(input logic bad);
		decoded_t d;
		logic [47:0] rest;
		logic [31:0] v;
		d = '0;
		d.bad = bad;
		d.len = count;
		if (bad) return d;
		rest = tail;
		if (n_disp == 2'd1) begin
			d.disp = {{8{tail[7]}}, tail[7:0]};
			rest = tail >> 8;
		end else if (n_disp >= 2'd2) begin
			d.disp = tail[15:0];
			rest = tail >> 16;
		end
		v = '0;
		if (n_imm == 3'd1) begin
			v = {24'd0, rest[7:0]};
			if (p_size == 3'd2 && p_op != x86d_pkg::O_IN && p_op != x86d_pkg::O_OUT && rest[7])
				v[15:8] = 8'hff;
		end else if (n_imm == 3'd2) v = {16'd0, rest[15:0]};
		else if (n_imm >= 3'd4) v = rest[31:0];
		else if (opc == 8'hd0 || opc == 8'hd1) v = 32'd1;
		d.opnd = v;
		d.op = p_op; d.src = p_src; d.dst = p_dst; d.lock = p_lock;
		d.seg = p_seg; d.rep = p_rep; d.size = p_size;
		return d;
	endfunction

	task automatic step_byte(input logic [7:0] b);
		int r;
		if (count != 8'd255) count = count + 8'd1;
		if (ph == x86d_pkg::PH_MODRM) decode_modrm(b, r);
		else if (ph == x86d_pkg::PH_TAIL) begin
			if (n_tail < 3'd6) begin
				tail = tail | (48'(b) << (8 * n_tail));
				n_tail = n_tail + 3'd1;
			end
			r = (n_tail >= {1'b0, n_disp} + n_imm || n_tail >= 3'd6) ? ST_DONE : ST_WAIT;
		end else decode_opcode(b, r);
		if (r != ST_WAIT) begin
			expected_records.push_back(build_record(r == ST_BAD));
			clear_decode();
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		decoded_t e;
		if (!arst_n) begin
			clear_decode();
			expected_records.delete();
			fail_count = 0;
			pending_records = 0;
			records_seen <= 0;
			rejects_seen <= 0;
		end else begin
			// output first: a record produced this edge lands in the queue after
			if (out_valid && out_ready) begin
				records_seen <= records_seen + 1;
				if (status) rejects_seen <= rejects_seen + 1;
				if (expected_records.size() == 0) begin
					$display("%0t unexpected record: status %0b length %0d", $time, status,
						length);
					fail_count++;
				end else begin
					e = expected_records.pop_front();
					compare_field("status", 32'(e.bad), 32'(status));
					compare_field("length", 32'(e.len), 32'(length));
					compare_field("operation", 32'(e.op), 32'(operation));
					compare_field("src_operand", 32'(e.src), 32'(src_operand));
					compare_field("dst_operand", 32'(e.dst), 32'(dst_operand));
					compare_field("lock_flag", 32'(e.lock), 32'(lock_flag));
					compare_field("segment_override", 32'(e.seg), 32'(segment_override));
					compare_field("repeat_mode", 32'(e.rep), 32'(repeat_mode));
					compare_field("op_size", 32'(e.size), 32'(op_size));
					compare_field("displacement", 32'(e.disp), {16'd0, displacement});
					compare_field("operand_value", e.opnd, operand_value);
				end
			end
			if (in_valid && in_ready) step_byte(code_byte);
			pending_records = expected_records.size();
		end
	end

endmodule

FILE: tb/sv/tb_x86_16bit_instruction_decoder.sv
// tb_x86_16bit_instruction_decoder: stimulus and verdict for the 8086 decoder
// depends on x86d_pkg, x86_16bit_instruction_decoder and x86d_checker
`timescale 1ns / 1ps

module tb_x86_16bit_instruction_decoder;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  code_byte;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [7:0]  length;
	logic [6:0]  operation;
	logic [4:0]  src_operand;
	logic [4:0]  dst_operand;
	logic        lock_flag;
	logic [2:0]  segment_override;
	logic [1:0]  repeat_mode;
	logic [2:0]  op_size;
	logic signed [15:0] displacement;
	logic [31:0] operand_value;

	int fail_count, pending_records, records_seen, rejects_seen;
	int bytes_sent;
	bit stim_done;
	bit calm;        // no idling on either side near the end
	bit hold_sink;   // long receiver hold-off to back the block up

	logic [7:0] stream[$];

	x86_16bit_instruction_decoder i_dut (.*);

	x86d_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// fixed watchdog, far above the slowest correct run
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	// build one instruction with random content and push its bytes
	task automatic add_instruction();
		logic [7:0] op, m;
		int k, tail;
		// prefixes now and then
		k = $urandom_range(0, 9);
		if (k == 0) stream.push_back(8'hf0);
		if (k == 1) stream.push_back(($urandom_range(0, 1)) ? 8'hf2 : 8'hf3);
		if (k == 2) stream.push_back(8'h26 | (8'($urandom_range(0, 3)) << 3));
		if (k == 3) begin
			stream.push_back(8'hf3);
			stream.push_back(8'h2e);
			stream.push_back(8'hf0);
		end
		op = 8'($urandom_range(0, 255));
		stream.push_back(op);
		// enough trailing bytes to finish most forms; leftovers start the next one
		if ((op < 8'h40 && op[2:1] == 2'b00) || (op >= 8'h80 && op <= 8'h8f) ||
				(op >= 8'hc4 && op <= 8'hc7) || (op >= 8'hd0 && op <= 8'hd3) ||
				(op >= 8'hd8 && op <= 8'hdf) || op >= 8'hf6) begin
			m = 8'($urandom_range(0, 255));
			stream.push_back(m);
			tail = (m[7:6] == 2'd3) ? 0 : (m[7:6] == 2'd0 && m[2:0] != 3'd6) ? 0
				: (m[7:6] == 2'd1) ? 1 : 2;
			if (op inside {8'h80, 8'h82, 8'h83, 8'hc6, 8'hf6}) tail += 1;
			if (op inside {8'h81, 8'hc7, 8'hf7}) tail += 2;
		end else tail = $urandom_range(0, 4);
		repeat (tail) stream.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic push_bytes(input logic [7:0] b[]);
		foreach (b[i]) stream.push_back(b[i]);
	endtask

	// sender: bytes from the stream, random idle bursts
	initial begin
		int gap;
		in_valid = 1'b0;
		code_byte = 8'h00;
		out_ready = 1'b0;
		arst_n = 1'b0;
		stim_done = 0;
		calm = 0;
		hold_sink = 0;
		bytes_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes and the special cases
		push_bytes('{8'h00, 8'hc0});                        // add al,al register form
		push_bytes('{8'h8b, 8'h06, 8'h34, 8'h12});          // direct address, 2-byte disp
		push_bytes('{8'h9a, 8'h78, 8'h56, 8'h34, 8'h12});   // far call pointer
		push_bytes('{8'hea, 8'hff, 8'hff, 8'hff, 8'hff});   // far jump
		push_bytes('{8'hd0, 8'he0, 8'hd1, 8'h47, 8'h80});   // shifts by one
		push_bytes('{8'h83, 8'hc0, 8'h80});                 // sign-extended byte immediate
		push_bytes('{8'he5, 8'hff});                        // in ax: no sign extension
		push_bytes('{8'h81, 8'h90, 8'h00, 8'h80, 8'hff, 8'hff}); // disp16 and imm16: four tail bytes
		push_bytes('{8'h0f, 8'h60, 8'hf1, 8'h8c});          // undefined opcodes
		push_bytes('{8'hc4, 8'hc0, 8'h8e, 8'he0});          // les reg, bad segment
		push_bytes('{8'hff, 8'hf8, 8'hfe, 8'h10});          // bad group 5/4 ext
		push_bytes('{8'hd8, 8'hc0});                        // esc register form
		push_bytes('{8'hf0, 8'hf2, 8'h26, 8'h3e, 8'ha4});   // prefixes, last seg wins
		push_bytes('{8'h75, 8'h80, 8'h90});
		// endless prefixes: saturating length
		repeat (300) stream.push_back(8'hf3);
		stream.push_back(8'hac);

		while (bytes_sent < 1850 || stream.size() != 0) begin
			if (stream.size() == 0) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise bytes
					repeat ($urandom_range(1, 4)) stream.push_back(8'($urandom_range(0, 255)));
				end else add_instruction();
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				gap = $urandom_range(1, 8);
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			code_byte <= stream.pop_front();
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			bytes_sent++;
			if (bytes_sent == 800) hold_sink = 1;
			if (bytes_sent >= 1600) calm = 1;
		end
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				gap = $urandom_range(1, 8);
				repeat (gap - 1) @(posedge clk);
			end else out_ready <= 1'b1;
		end
	end

	// verdict once everything has drained
	initial begin
		@(posedge arst_n);
		wait (stim_done);
		while (pending_records != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d code bytes, checked %0d records of which %0d were rejections",
			bytes_sent, records_seen, rejects_seen);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/x86d_pkg.sv
rtl/core/x86_16bit_instruction_decoder.sv
tb/sv/x86d_checker.sv
tb/sv/tb_x86_16bit_instruction_decoder.sv
